// ===== design/oat_pkg.sv =====
`default_nettype none

package oat_pkg;

    localparam int OAT_DEPTH = 256;
    localparam int OAT_WIDTH = 32;

    localparam int FUNC_W   = 4;
    localparam int INDEX_W  = 8;
    localparam int VALUE_W  = 32;
    localparam int RDATA_W  = 32;
    localparam int POS_W    = 8;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 9;

    // Request function codes.
    localparam logic [FUNC_W-1:0] FN_APPEND = 4'd0;
    localparam logic [FUNC_W-1:0] FN_INSERT = 4'd1;
    localparam logic [FUNC_W-1:0] FN_POP    = 4'd2;
    localparam logic [FUNC_W-1:0] FN_ERASE  = 4'd3;
    localparam logic [FUNC_W-1:0] FN_REMOVE = 4'd4;
    localparam logic [FUNC_W-1:0] FN_FIND   = 4'd5;
    localparam logic [FUNC_W-1:0] FN_READ   = 4'd6;
    localparam logic [FUNC_W-1:0] FN_FRONT  = 4'd7;
    localparam logic [FUNC_W-1:0] FN_BACK   = 4'd8;

    // Response status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

    // Cell update operations.
    localparam logic [1:0] CELL_HOLD       = 2'd0;
    localparam logic [1:0] CELL_SHIFT_UP   = 2'd1;
    localparam logic [1:0] CELL_SHIFT_DOWN = 2'd2;

    typedef struct packed {
        logic [1:0] op;
        logic       by_value;
    } oat_cell_ctrl_t;

endpackage

`default_nettype wire

// ===== design/oat_req_if.sv =====
`default_nettype none

interface oat_req_if
    import oat_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [FUNC_W-1:0]  func;
    logic [INDEX_W-1:0] index;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output func, output index, output value, input ready);
    modport sink   (input valid, input func, input index, input value, output ready);
endinterface

`default_nettype wire

// ===== design/oat_rsp_if.sv =====
`default_nettype none

interface oat_rsp_if
    import oat_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [RDATA_W-1:0]  read_data;
    logic [POS_W-1:0]    position;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
    logic                is_empty;

    modport source (output valid, output read_data, output position, output status,
                    output count, output is_empty, input ready);
    modport sink   (input valid, input read_data, input position, input status,
                    input count, input is_empty, output ready);
endinterface

`default_nettype wire

// ===== design/oat_cell.sv =====
`default_nettype none

module oat_cell
    import oat_pkg::*;
#(
    parameter int WIDTH = OAT_WIDTH,
    parameter int AW    = 8,
    parameter int CW    = 9,
    parameter int INDEX = 0
) (
    input  wire logic           clk,
    input  wire oat_cell_ctrl_t ctrl,
    input  wire logic [AW-1:0]  pos,
    input  wire logic [WIDTH-1:0] key,
    input  wire logic [CW-1:0]  count,
    input  wire logic [WIDTH-1:0] left_data,
    input  wire logic [WIDTH-1:0] right_data,
    output logic [WIDTH-1:0]    data,
    output logic                hit
);

    localparam logic [AW-1:0] MY_POS = AW'(INDEX);
    localparam logic [CW-1:0] MY_CNT = CW'(INDEX);

    logic [WIDTH-1:0] data_reg;
    logic [WIDTH-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (ctrl.op)
            CELL_SHIFT_UP:
            begin
                if (MY_POS > pos)
                begin
                    data_next = left_data;
                end
                else if (MY_POS == pos)
                begin
                    data_next = key;
                end
            end
            CELL_SHIFT_DOWN:
            begin
                if (MY_POS >= pos)
                begin
                    data_next = right_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    // A value search only sees live entries; an index search picks one cell.
    assign hit  = ctrl.by_value ? ((data_reg == key) && (MY_CNT < count)) : (MY_POS == pos);
    assign data = data_reg;

endmodule

`default_nettype wire

// ===== design/oat_tree.sv =====
`default_nettype none

module oat_tree
    import oat_pkg::*;
#(
    parameter int DEPTH = OAT_DEPTH,
    parameter int WIDTH = OAT_WIDTH,
    parameter int AW    = 8
) (
    input  wire logic             clk,
    input  wire logic             hit [DEPTH],
    input  wire logic [WIDTH-1:0] data [DEPTH],
    output logic                  root_hit,
    output logic [AW-1:0]         root_pos,
    output logic [WIDTH-1:0]      root_data
);

    localparam int N = 1 << AW;

    logic             pad_hit  [N];
    logic [WIDTH-1:0] pad_data [N];

    // Heap layout: node k has children 2k and 2k+1, leaves sit at N..2N-1.
    logic             node_hit_reg  [1:2*N-1];
    logic [AW-1:0]    node_pos_reg  [1:2*N-1];
    logic [WIDTH-1:0] node_data_reg [1:2*N-1];

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_pad
            if (g < DEPTH)
            begin : g_live
                assign pad_hit[g]  = hit[g];
                assign pad_data[g] = data[g];
            end
            else
            begin : g_fill
                assign pad_hit[g]  = 1'b0;
                assign pad_data[g] = '0;
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < N; i++)
        begin
            node_hit_reg[N+i]  <= pad_hit[i];
            node_pos_reg[N+i]  <= AW'(i);
            node_data_reg[N+i] <= pad_data[i];
        end
        // The lower position wins, so the root holds the first hit.
        for (int k = 1; k < N; k++)
        begin
            if (node_hit_reg[2*k])
            begin
                node_hit_reg[k]  <= 1'b1;
                node_pos_reg[k]  <= node_pos_reg[2*k];
                node_data_reg[k] <= node_data_reg[2*k];
            end
            else
            begin
                node_hit_reg[k]  <= node_hit_reg[2*k+1];
                node_pos_reg[k]  <= node_pos_reg[2*k+1];
                node_data_reg[k] <= node_data_reg[2*k+1];
            end
        end
    end

    assign root_hit  = node_hit_reg[1];
    assign root_pos  = node_pos_reg[1];
    assign root_data = node_data_reg[1];

endmodule

`default_nettype wire

// ===== design/ordered_array_table.sv =====
// ordered_array_table: a positional list of up to DEPTH words of WIDTH bits.
// Requests arrive on the req channel (func, index, value) and each one gives
// exactly one transaction on the rsp channel (read_data, position, status,
// count, is_empty). Both channels use a valid/ready handshake.
// The list lives in a row of DEPTH cells; each cell holds one entry and can
// load from its lower or upper neighbor, so insert and erase move the whole
// tail at once. Lookups (find, remove by value, read at, front, back)
// let every cell flag a hit at once and pick the first hit through a
// registered binary tree with log2(DEPTH) levels.
// Append, insert, pop, erase at and every rejected request load the
// response register from the execute state; lookups pass through the
// search and finish states first. One request is in work at a time;
// the next is taken once the block is back in idle after the response
// is loaded. The tree depth sets the length of a lookup.
// The response sits in an output register, so a new request is accepted
// while the receiver stalls; its result waits until that register frees.
// Reset empties the list at once; no clearing pass is needed.
`default_nettype none

module ordered_array_table
    import oat_pkg::*;
#(
    parameter int DEPTH = OAT_DEPTH,
    parameter int WIDTH = OAT_WIDTH
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    oat_req_if.sink    req,
    oat_rsp_if.source  rsp
);

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > INDEX_W) ? CW : INDEX_W;
    localparam int SCW  = $clog2(AW + 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EXEC   = 2'd1;
    localparam logic [1:0] S_SEARCH = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0]          state_reg;
    logic [1:0]          state_next;
    logic [FUNC_W-1:0]   func_reg;
    logic [INDEX_W-1:0]  idx_reg;
    logic [WIDTH-1:0]    key_reg;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic [SCW-1:0]      step_reg;
    logic [SCW-1:0]      step_next;

    logic                rsp_valid_reg;
    logic [RDATA_W-1:0]  rd_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [COUNT_W-1:0]  cnt_out_reg;
    logic                empty_reg;

    logic [RDATA_W-1:0]  res_rd;
    logic [POS_W-1:0]    res_pos;
    logic [STATUS_W-1:0] res_status;

    oat_cell_ctrl_t      ctrl;
    logic [1:0]          op_pre;
    logic [AW-1:0]       pos_bus;
    logic [AW-1:0]       search_pos;
    logic                commit;
    logic                out_free;
    logic                full;
    logic                empty;
    logic [CMPW-1:0]     idx_w;
    logic [CMPW-1:0]     cnt_w;

    logic                cell_hit  [DEPTH];
    logic [WIDTH-1:0]    cell_data [DEPTH];
    logic                root_hit;
    logic [AW-1:0]       root_pos;
    logic [WIDTH-1:0]    root_data;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign idx_w    = CMPW'(idx_reg);
    assign cnt_w    = CMPW'(count_reg);
    assign out_free = !rsp_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE);

    always_comb
    begin
        case (func_reg)
            FN_READ:  search_pos = AW'(idx_reg);
            FN_BACK:  search_pos = AW'(count_reg - CW'(1));
            default:  search_pos = '0;
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        count_next    = count_reg;
        commit        = 1'b0;
        op_pre        = CELL_HOLD;
        pos_bus       = search_pos;
        res_rd        = '0;
        res_pos       = '0;
        res_status    = ST_OK;
        ctrl.by_value = (func_reg == FN_REMOVE) || (func_reg == FN_FIND);

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (func_reg)
                    FN_APPEND:
                    begin
                        if (full)
                        begin
                            res_status = ST_FULL;
                        end
                        else
                        begin
                            op_pre     = CELL_SHIFT_UP;
                            pos_bus    = AW'(count_reg);
                            count_next = count_reg + CW'(1);
                        end
                    end
                    FN_INSERT:
                    begin
                        if (full)
                        begin
                            res_status = ST_FULL;
                        end
                        else if (idx_w > cnt_w)
                        begin
                            res_status = ST_RANGE;
                        end
                        else
                        begin
                            op_pre     = CELL_SHIFT_UP;
                            pos_bus    = AW'(idx_reg);
                            count_next = count_reg + CW'(1);
                        end
                    end
                    FN_POP:
                    begin
                        if (empty)
                        begin
                            res_status = ST_RANGE;
                        end
                        else
                        begin
                            count_next = count_reg - CW'(1);
                        end
                    end
                    FN_ERASE:
                    begin
                        if (idx_w >= cnt_w)
                        begin
                            res_status = ST_RANGE;
                        end
                        else
                        begin
                            op_pre     = CELL_SHIFT_DOWN;
                            pos_bus    = AW'(idx_reg);
                            count_next = count_reg - CW'(1);
                        end
                    end
                    FN_REMOVE, FN_FIND:
                    begin
                        state_next = S_SEARCH;
                    end
                    FN_READ:
                    begin
                        if (idx_w >= cnt_w)
                        begin
                            res_status = ST_RANGE;
                        end
                        else
                        begin
                            state_next = S_SEARCH;
                        end
                    end
                    FN_FRONT, FN_BACK:
                    begin
                        if (empty)
                        begin
                            res_status = ST_RANGE;
                        end
                        else
                        begin
                            state_next = S_SEARCH;
                        end
                    end
                    default:
                    begin
                        res_status = ST_RANGE;
                    end
                endcase

                if (state_next == S_SEARCH)
                begin
                    step_next  = '0;
                    count_next = count_reg;
                end
                else if (out_free)
                begin
                    commit     = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    count_next = count_reg;
                end
            end
            S_SEARCH:
            begin
                // Leaves load on the first edge, then one tree level per edge.
                step_next = step_reg + SCW'(1);
                if (step_reg == SCW'(AW))
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                case (func_reg)
                    FN_REMOVE:
                    begin
                        pos_bus = root_pos;
                        if (root_hit)
                        begin
                            op_pre     = CELL_SHIFT_DOWN;
                            res_pos    = POS_W'(root_pos);
                            count_next = count_reg - CW'(1);
                        end
                        else
                        begin
                            res_status = ST_NOTFOUND;
                        end
                    end
                    FN_FIND:
                    begin
                        if (root_hit)
                        begin
                            res_pos = POS_W'(root_pos);
                        end
                        else
                        begin
                            res_status = ST_NOTFOUND;
                        end
                    end
                    default:
                    begin
                        res_rd = RDATA_W'(root_data);
                    end
                endcase

                if (out_free)
                begin
                    commit     = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    count_next = count_reg;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        ctrl.op = commit ? op_pre : CELL_HOLD;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            step_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            step_reg  <= step_next;
            if (commit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            func_reg <= req.func;
            idx_reg  <= req.index;
            key_reg  <= WIDTH'(req.value);
        end
        if (commit)
        begin
            rd_reg      <= res_rd;
            pos_reg     <= res_pos;
            status_reg  <= res_status;
            cnt_out_reg <= COUNT_W'(count_next);
            empty_reg   <= (count_next == '0);
        end
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic [WIDTH-1:0] left_data;
            logic [WIDTH-1:0] right_data;

            if (g == 0)
            begin : g_first
                assign left_data = '0;
            end
            else
            begin : g_left
                assign left_data = cell_data[g-1];
            end

            if (g == DEPTH - 1)
            begin : g_last
                assign right_data = '0;
            end
            else
            begin : g_right
                assign right_data = cell_data[g+1];
            end

            oat_cell #(
                .WIDTH (WIDTH),
                .AW    (AW),
                .CW    (CW),
                .INDEX (g)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .pos        (pos_bus),
                .key        (key_reg),
                .count      (count_reg),
                .left_data  (left_data),
                .right_data (right_data),
                .data       (cell_data[g]),
                .hit        (cell_hit[g])
            );
        end
    endgenerate

    oat_tree #(
        .DEPTH (DEPTH),
        .WIDTH (WIDTH),
        .AW    (AW)
    ) u_tree (
        .clk       (clk),
        .hit       (cell_hit),
        .data      (cell_data),
        .root_hit  (root_hit),
        .root_pos  (root_pos),
        .root_data (root_data)
    );

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.read_data = rd_reg;
    assign rsp.position  = pos_reg;
    assign rsp.status    = status_reg;
    assign rsp.count     = cnt_out_reg;
    assign rsp.is_empty  = empty_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("element count exceeds the table depth");

    a_count_only_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
        !commit |=> $stable(count_reg))
        else $error("element count changed without a completed request");

    a_commit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        commit |-> (!rsp_valid_reg || rsp.ready))
        else $error("response overwritten before it was taken");

    a_search_is_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH) |-> (func_reg == FN_REMOVE || func_reg == FN_FIND ||
            func_reg == FN_READ || func_reg == FN_FRONT || func_reg == FN_BACK))
        else $error("tree search started for a request that needs no lookup");
`endif

endmodule

`default_nettype wire
